// ----- rtl/core/mtpt_pkg.sv -----
// Package for the multiturn position tracker: register indexes, angle format
// codes, shift amounts and the angle alignment function. No dependencies.
package mtpt_pkg;

    localparam int unsigned AngleWidth  = 32;
    localparam int unsigned RawWidth    = 24;
    localparam int unsigned TurnWidth   = 16;
    localparam int unsigned CfgWidth    = 32;
    localparam int unsigned CfgIdxWidth = 1;

    localparam logic [CfgIdxWidth-1:0] REG_ANGLE_FORMAT    = 1'b0;
    localparam logic [CfgIdxWidth-1:0] REG_POSITION_OFFSET = 1'b1;

    localparam logic [1:0] FMT_BITS23 = 2'd0;
    localparam logic [1:0] FMT_BITS17 = 2'd1;
    localparam logic [1:0] FMT_BITS14 = 2'd2;

    localparam logic [TurnWidth-1:0] TURN_MIN = 16'h8000;
    localparam logic [TurnWidth-1:0] TURN_MAX = 16'h7fff;

    localparam logic [1:0] QUAD_BOTTOM = 2'b00;
    localparam logic [1:0] QUAD_TOP    = 2'b11;

    function automatic logic [AngleWidth-1:0] align_angle(
        input logic [RawWidth-1:0] raw,
        input logic [1:0]          fmt
    );
        logic [AngleWidth-1:0] wide;
        logic [AngleWidth-1:0] res;
        wide = {{(AngleWidth-RawWidth){1'b0}}, raw};
        unique case (fmt)
            FMT_BITS17: res = wide << 15;
            FMT_BITS14: res = wide << 18;
            default:    res = wide << 9;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/core/multiturn_position_tracker.sv -----
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; the single result register is the only stage,
// and a new item is taken whenever that register is empty or being drained.
// Reset (i_rst_n low, synchronous): angle, turn count, index capture, sticky
// flags and configuration clear to zero; the result register empties.
// Depends on mtpt_pkg.
module multiturn_position_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mtpt_pkg::CfgIdxWidth-1:0]    i_cfg_idx,
    input  logic [mtpt_pkg::CfgWidth-1:0]       i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_rx_ok,
    input  logic [mtpt_pkg::RawWidth-1:0]       i_single_turn,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [31:0]                  o_position,
    output logic signed [31:0]                  o_index_position,
    output logic                                o_origin_event,
    output logic                                o_wrap_seen,
    output logic                                o_pos_captured
);

    logic [1:0]                          r_fmt;
    logic [31:0]                         r_offset;
    logic [mtpt_pkg::AngleWidth-1:0]     r_angle;
    logic [mtpt_pkg::TurnWidth-1:0]      r_turn;
    logic [31:0]                         r_index;
    logic                                r_wrap_flag;
    logic                                r_cap_flag;
    logic                                r_out_valid;
    logic [31:0]                         r_position;
    logic [31:0]                         r_index_out;
    logic                                r_origin;

    logic                                w_accept;
    logic [mtpt_pkg::AngleWidth-1:0]     w_fresh;
    logic                                w_dec;
    logic                                w_inc;
    logic [mtpt_pkg::TurnWidth-1:0]      w_turn_inc;
    logic [mtpt_pkg::TurnWidth-1:0]      w_boundary;
    logic                                w_wrap;
    logic [mtpt_pkg::AngleWidth-1:0]     n_angle;
    logic [mtpt_pkg::TurnWidth-1:0]      n_turn;
    logic [31:0]                         n_index;
    logic                                n_wrap_flag;
    logic                                n_cap_flag;
    logic                                n_origin;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_fresh    = mtpt_pkg::align_angle(i_single_turn, r_fmt);
        w_dec      = i_rx_ok && (r_angle[31:30] == mtpt_pkg::QUAD_BOTTOM) && w_fresh[31];
        w_inc      = i_rx_ok && (r_angle[31:30] == mtpt_pkg::QUAD_TOP) && !w_fresh[31];
        w_turn_inc = r_turn + 16'd1;
        w_boundary = w_dec ? r_turn : w_turn_inc;
        w_wrap     = (w_dec && (r_turn == mtpt_pkg::TURN_MIN))
                  || (w_inc && (r_turn == mtpt_pkg::TURN_MAX));
        n_origin   = w_dec || w_inc;
        n_angle    = i_rx_ok ? w_fresh : r_angle;
        priority if (w_dec) begin
            n_turn = r_turn - 16'd1;
        end else if (w_inc) begin
            n_turn = w_turn_inc;
        end else begin
            n_turn = r_turn;
        end
        n_index     = n_origin ? ({w_boundary, 16'h0000} + r_offset) : r_index;
        n_wrap_flag = r_wrap_flag || w_wrap;
        n_cap_flag  = r_cap_flag || n_origin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= mtpt_pkg::FMT_BITS23;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mtpt_pkg::REG_ANGLE_FORMAT:    r_fmt    <= i_cfg_data[1:0];
                mtpt_pkg::REG_POSITION_OFFSET: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle     <= '0;
            r_turn      <= '0;
            r_index     <= '0;
            r_wrap_flag <= 1'b0;
            r_cap_flag  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_angle     <= n_angle;
                r_turn      <= n_turn;
                r_index     <= n_index;
                r_wrap_flag <= n_wrap_flag;
                r_cap_flag  <= n_cap_flag;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_position  <= {n_turn, n_angle[31:16]};
            r_index_out <= n_index;
            r_origin    <= n_origin;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_position       = r_position;
    assign o_index_position = r_index_out;
    assign o_origin_event   = r_origin;
    assign o_wrap_seen      = r_wrap_flag;
    assign o_pos_captured   = r_cap_flag;

    a_origin_sets_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_origin_event |-> o_pos_captured)
        else $error("origin item without captured flag");

    a_failed_reply_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_rx_ok |=> $stable(r_angle) && $stable(r_turn) && $stable(r_index))
        else $error("failed reply changed tracker state");

    a_wrap_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrap_flag |=> r_wrap_flag)
        else $error("wrap flag cleared");

    a_captured_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap_flag |=> r_cap_flag)
        else $error("captured flag cleared");

    a_turn_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_origin |=> (r_turn == $past(r_turn) + 16'd1)
                              || (r_turn == $past(r_turn) - 16'd1))
        else $error("turn count moved by more than one");

endmodule
